// ===== rtl/epd_pkg.sv =====
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types, constants and the code-to-length table of the escaped
// packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package epd_pkg;

   // byte values with a meaning on the link
   localparam logic [7:0] ESC_BYTE     = 8'h1B;
   localparam logic [7:0] ROUTING_CODE = 8'h22;

   // response codes
   localparam logic [7:0] CODE_S01 = 8'h01;
   localparam logic [7:0] CODE_S05 = 8'h05;
   localparam logic [7:0] CODE_S16 = 8'h16;
   localparam logic [7:0] CODE_S17 = 8'h17;
   localparam logic [7:0] CODE_S24 = 8'h24;
   localparam logic [7:0] CODE_S28 = 8'h28;
   localparam logic [7:0] CODE_S2B = 8'h2B;
   localparam logic [7:0] CODE_S40 = 8'h40;
   localparam logic [7:0] CODE_M11 = 8'h11;
   localparam logic [7:0] CODE_L8A = 8'h8A;
   localparam logic [7:0] CODE_L8C = 8'h8C;
   localparam logic [7:0] CODE_L84 = 8'h84;

   // cell count above which routing-key packets are long
   localparam logic [7:0] LONG_KEY_CELLS = 8'd40;
   localparam logic [7:0] CELL_COUNT_RST = 8'd40;

   // input kind flag
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   // packet length and byte position width
   localparam int LEN_W = 5;

   typedef logic [LEN_W-1:0] len_type;

   // handover of a completed packet to the read-out side
   typedef struct packed {
      logic    valid;
      len_type length;
   } drain_req_type;

   // packet length for a code, zero for an unknown code
   function automatic len_type length_for_code(input logic [7:0] code,
                                               input logic       long_keys);
      len_type len;
      unique case (code) inside
         CODE_S01, CODE_S05, CODE_S16, CODE_S17,
         CODE_S24, CODE_S28, CODE_S2B, CODE_S40: len = len_type'(2);
         CODE_M11:                               len = len_type'(3);
         CODE_L8A:                               len = len_type'(9);
         CODE_L8C:                               len = len_type'(15);
         CODE_L84:                               len = len_type'(17);
         ROUTING_CODE: len = long_keys ? len_type'(11) : len_type'(6);
         default:                                len = '0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/epd_store.sv =====
// ----------------------------------------------------------------------------
// epd_store
// Packet byte memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module epd_store #(
   parameter int PACKET_DEPTH = 17,
   parameter int AW           = $clog2(PACKET_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [PACKET_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/epd_parse.sv =====
// ----------------------------------------------------------------------------
// epd_parse
// Unstuffs the byte stream, tracks the packet being assembled and writes
// its bytes into the packet memory; hands a complete packet to read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module epd_parse #(
   parameter int PACKET_DEPTH = 17,
   parameter int AW           = $clog2(PACKET_DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  kind,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  long_keys,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [7:0]                 wr_data,
   output epd_pkg::drain_req_type     drain_req
);

   localparam int FW = $clog2(PACKET_DEPTH + 1);

   logic                started_ff, started_in;
   logic                esc_ff, esc_in;
   logic [FW-1:0]       fill_ff, fill_in;
   epd_pkg::len_type    explen_ff, explen_in;
   epd_pkg::len_type    code_len;
   logic                take;

   assign code_len = epd_pkg::length_for_code(rx_byte, long_keys);

   // next state for one input beat
   always_comb begin
      started_in = started_ff;
      esc_in     = esc_ff;
      fill_in    = fill_ff;
      explen_in  = explen_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = rx_byte;
      drain_req  = '0;
      take       = 1'b0;
      if (accept) begin
         if (kind == epd_pkg::KIND_TIMEOUT) begin
            started_in = 1'b0;
            esc_in     = 1'b0;
            fill_in    = '0;
            explen_in  = '0;
         end else begin
            take = 1'b1;
            // escape handling
            if (rx_byte == epd_pkg::ESC_BYTE) begin
               esc_in = !esc_ff;
               if (!esc_ff) begin
                  take = 1'b0;
               end
            end else if (esc_ff) begin
               esc_in = 1'b0;
               if (fill_ff != '0) begin
                  fill_in = '0;
               end else begin
                  started_in = 1'b1;
               end
            end
            if (take && !started_in) begin
               take = 1'b0;
            end
            // code byte picks the length
            if (take && fill_in == '0) begin
               if (code_len == '0) begin
                  started_in = 1'b0;
                  take       = 1'b0;
               end else begin
                  explen_in = code_len;
               end
            end
            // overrun guard
            if (take && (fill_in >= FW'(PACKET_DEPTH) || fill_in >= FW'(explen_in))) begin
               started_in = 1'b0;
               esc_in     = 1'b0;
               fill_in    = '0;
               explen_in  = '0;
               take       = 1'b0;
            end
            // store the byte, hand over when complete
            if (take) begin
               wr_en   = 1'b1;
               wr_addr = fill_in[AW-1:0];
               fill_in = fill_in + FW'(1);
               if (fill_in == FW'(explen_in)) begin
                  drain_req.valid  = 1'b1;
                  drain_req.length = explen_in;
                  started_in       = 1'b0;
                  esc_in           = 1'b0;
                  fill_in          = '0;
                  explen_in        = '0;
               end
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         esc_ff     <= 1'b0;
         fill_ff    <= '0;
         explen_ff  <= '0;
      end else begin
         started_ff <= started_in;
         esc_ff     <= esc_in;
         fill_ff    <= fill_in;
         explen_ff  <= explen_in;
      end
   end

   // a packet is handed over only together with the write of its last byte
   a_drain_with_write: assert property (@(posedge clock) disable iff (reset)
      drain_req.valid |-> wr_en)
      else $error("packet handed over without its final byte write");

   // bytes are stored only inside a started packet
   a_write_started: assert property (@(posedge clock) disable iff (reset)
      wr_en && !drain_req.valid |=> started_ff && fill_ff != '0)
      else $error("stored byte left no open packet behind");

endmodule

`default_nettype wire

// ===== rtl/epd_drain.sv =====
// ----------------------------------------------------------------------------
// epd_drain
// Reads a completed packet back from memory one byte a cycle while the output
// stage can take it, and presents it on the result channel through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module epd_drain #(
   parameter int PACKET_DEPTH = 17,
   parameter int AW           = $clog2(PACKET_DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire epd_pkg::drain_req_type drain_req,
   output logic                        busy,
   output logic                        rd_en,
   output logic [AW-1:0]               rd_addr,
   input  wire logic [7:0]             rd_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_byte,
   output epd_pkg::len_type            rsp_index,
   output logic                        rsp_last
);

   logic             active_ff, active_in;
   epd_pkg::len_type idx_ff, idx_in;
   epd_pkg::len_type len_ff, len_in;
   logic             s1_valid_ff, s1_valid_in;
   epd_pkg::len_type s1_idx_ff;
   logic             s1_last_ff;
   logic             s2_valid_ff, s2_valid_in;
   logic [7:0]       s2_byte_ff;
   epd_pkg::len_type s2_idx_ff;
   logic             s2_last_ff;
   logic             s2_load;
   logic             issue_last;

   // stage movement
   assign s2_load    = !s2_valid_ff || rsp_ready;
   assign rd_en      = active_ff && (!s1_valid_ff || s2_load);
   assign rd_addr    = idx_ff[AW-1:0];
   assign issue_last = (idx_ff + epd_pkg::len_type'(1)) == len_ff;
   assign busy       = active_ff;

   // read sequencer
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      if (drain_req.valid) begin
         active_in = 1'b1;
         idx_in    = '0;
         len_in    = drain_req.length;
      end else if (rd_en) begin
         idx_in = idx_ff + epd_pkg::len_type'(1);
         if (issue_last) begin
            active_in = 1'b0;
         end
      end
   end

   assign s1_valid_in = rd_en || (s1_valid_ff && !s2_load);
   assign s2_valid_in = (s1_valid_ff && s2_load) || (s2_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      if (rd_en) begin
         s1_idx_ff  <= idx_ff;
         s1_last_ff <= issue_last;
      end
      if (s1_valid_ff && s2_load) begin
         s2_byte_ff <= rd_data;
         s2_idx_ff  <= s1_idx_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_byte  = s2_byte_ff;
   assign rsp_index = s2_idx_ff;
   assign rsp_last  = s2_last_ff;

   // no new packet may arrive while one is still being read out
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      drain_req.valid |-> !active_ff)
      else $error("packet handed over during read-out");

   // the read of the final byte ends the sequence
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rd_en && issue_last |=> !active_ff)
      else $error("read-out continued past the last byte");

   // a read always lands in the first stage
   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_valid_ff)
      else $error("memory read lost");

endmodule

`default_nettype wire

// ===== rtl/escaped_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// escaped_packet_deframer
// Recovers escape-stuffed response packets from a received byte stream and
// emits each completed packet byte by byte with a last flag.
// ----------------------------------------------------------------------------
// Input beats are taken one per cycle while a packet is being assembled;
// each stored byte goes into the packet memory. When the final byte of a
// packet arrives, req_tready drops while the memory's single read port reads
// the packet back one byte a cycle while the output registers can take it.
// A packet holds 2 to 17 bytes; read-out stalls while the result side stalls
// and its two output registers are full. After the final input beat is
// accepted, the read-out start is registered in the active flag and each
// byte then passes the two output registers; the result side delivers one
// beat per cycle when rsp_tready is held high.
`default_nettype none

module escaped_packet_deframer #(
   parameter int PACKET_DEPTH = 17
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] kind
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] packet_byte, [12:8] byte_index
   output logic             rsp_tlast,   // last
   // configuration
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata    // cell_count
);

   localparam int AW = $clog2(PACKET_DEPTH);

   logic                   cell_count_ff;
   logic [7:0]             cell_count_reg_ff;
   logic                   accept;
   logic                   busy;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [7:0]             wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [7:0]             rd_data;
   epd_pkg::drain_req_type drain_req;
   logic [7:0]             rsp_byte;
   epd_pkg::len_type       rsp_index;

   // cell count register and its routing-key length select
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_reg_ff <= epd_pkg::CELL_COUNT_RST;
      end else if (csr_we) begin
         cell_count_reg_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= 1'b0;
      end else begin
         cell_count_ff <= (csr_we ? csr_wdata : cell_count_reg_ff) > epd_pkg::LONG_KEY_CELLS;
      end
   end

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   epd_parse #(
      .PACKET_DEPTH (PACKET_DEPTH),
      .AW           (AW)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_tuser),
      .rx_byte   (req_tdata),
      .long_keys (cell_count_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .drain_req (drain_req)
   );

   epd_store #(
      .PACKET_DEPTH (PACKET_DEPTH),
      .AW           (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   epd_drain #(
      .PACKET_DEPTH (PACKET_DEPTH),
      .AW           (AW)
   ) u_drain (
      .clock     (clock),
      .reset     (reset),
      .drain_req (drain_req),
      .busy      (busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_byte  (rsp_byte),
      .rsp_index (rsp_index),
      .rsp_last  (rsp_tlast)
   );

   // result beat packing
   assign rsp_tdata = {3'b000, rsp_index, rsp_byte};

endmodule

`default_nettype wire
